FILE: hw/rtl/sncp_pkg.sv
// Package for the segment near-clip and projection unit.
// Word types, fixed-point widths, near epsilon and helper functions.
// Depends on nothing.
`default_nettype none

package sncp_pkg;

   localparam int MATRIX_FRAC_BITS = 12;
   localparam int WORLD_FRAC_BITS  = 16;
   localparam int SCREEN_FRAC_BITS = 4;
   localparam int CLIP_FRAC_BITS   = MATRIX_FRAC_BITS + WORLD_FRAC_BITS;

   localparam int ENTRY_W = 16;
   localparam int COORD_W = 32;
   localparam int PROD_W  = ENTRY_W + COORD_W;
   localparam int OUT_W   = 24;

   // clip space: three 2^46 products plus the w term stay below 2^48
   localparam int CW  = 49;
   localparam int DW  = CW + 1;
   localparam int MW  = CW;
   localparam int HC  = (MW + 1) / 2;
   localparam int PPW = 2 * HC;
   localparam int QC  = MW + 1;
   localparam int DVC = 2 * MW + 1;

   // screen stage
   localparam int SW  = CW + 2;
   localparam int SAW = SW + 1;
   localparam int SMW = SW;
   localparam int SH  = (SMW + 1) / 2;
   localparam int WDW = 16 + SCREEN_FRAC_BITS;
   localparam int SDV = SMW + WDW + 1;
   localparam int UCW = CW + 1;
   localparam int QS  = 26;
   localparam int FW  = ((QS + 2) > (17 + SCREEN_FRAC_BITS) ?
                         (QS + 2) : (17 + SCREEN_FRAC_BITS)) + 1;

   localparam longint NEAR_EPS_L = ((longint'(1) << CLIP_FRAC_BITS) + 500) / 1000;
   localparam logic signed [CW-1:0] NEAR_EPS = CW'(NEAR_EPS_L);
   localparam logic [ENTRY_W-1:0] MAT_ONE = ENTRY_W'(1 << MATRIX_FRAC_BITS);

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 64;

   typedef enum logic [CSR_AW-1:0] {
      CSR_ROW0   = 3'd0,
      CSR_ROW1   = 3'd1,
      CSR_ROW2   = 3'd2,
      CSR_ROW3   = 3'd3,
      CSR_ORIGIN = 3'd4,
      CSR_SIZE   = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] a_z;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic signed [COORD_W-1:0] b_z;
   } req_word_type;

   typedef struct packed {
      logic                    visible;
      logic signed [OUT_W-1:0] screen_a_x;
      logic signed [OUT_W-1:0] screen_a_y;
      logic signed [OUT_W-1:0] screen_b_x;
      logic signed [OUT_W-1:0] screen_b_y;
   } rsp_word_type;

   function automatic logic [MW-1:0] mag_c(logic signed [DW-1:0] v);
      logic signed [DW-1:0] n;
      n = -v;
      return v[DW-1] ? n[MW-1:0] : v[MW-1:0];
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(logic signed [FW-1:0] v);
      logic signed [FW-1:0] hi;
      logic signed [FW-1:0] lo;
      hi = FW'((longint'(1) << (OUT_W - 1)) - 1);
      lo = -FW'(longint'(1) << (OUT_W - 1));
      if (v > hi) return hi[OUT_W-1:0];
      if (v < lo) return lo[OUT_W-1:0];
      return v[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/segment_near_clip_project_unit.sv
// Segment near-plane clip and viewport projection, fully pipelined.
// Throughput: one word per cycle; a stall on the response side holds every stage.
// Dividers are unrolled restoring pipelines, one quotient bit per stage.
// Reset (synchronous) clears valid bits and loads the identity matrix,
// zero origin and zero viewport size.
// Depends on sncp_pkg.
`default_nettype none

module segment_near_clip_project_unit import sncp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_word_type        req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_word_type        rsp_data,
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [CSR_DW-1:0]   csr_wdata
);

   typedef struct {
      logic                 fa;
      logic                 fb;
      logic [2:0]           neg;
      logic [MW-1:0]        den;
      logic signed [CW-1:0] ca [4];
      logic signed [CW-1:0] cb [4];
   } clip_side_type;

   typedef struct {
      logic           vis;
      logic [3:0]     neg;
      logic [3:0]     ovf;
      logic [UCW-1:0] uca;
      logic [UCW-1:0] ucb;
   } scr_side_type;

   // ---------------- configuration
   logic [63:0] row_ff [4];
   logic [31:0] origin_ff;
   logic [31:0] size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= {48'd0, MAT_ONE};
         row_ff[1] <= {32'd0, MAT_ONE, 16'd0};
         row_ff[2] <= {16'd0, MAT_ONE, 32'd0};
         row_ff[3] <= {MAT_ONE, 48'd0};
         origin_ff <= '0;
         size_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ROW0:   row_ff[0] <= csr_wdata;
            CSR_ROW1:   row_ff[1] <= csr_wdata;
            CSR_ROW2:   row_ff[2] <= csr_wdata;
            CSR_ROW3:   row_ff[3] <= csr_wdata;
            CSR_ORIGIN: origin_ff <= csr_wdata[31:0];
            CSR_SIZE:   size_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   logic signed [ENTRY_W-1:0] mat [4][4];
   logic signed [COORD_W-1:0] pt [2][3];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            mat[i][j] = row_ff[i][16*j +: 16];
         end
      end
      pt[0][0] = req_data.a_x;
      pt[0][1] = req_data.a_y;
      pt[0][2] = req_data.a_z;
      pt[1][0] = req_data.b_x;
      pt[1][1] = req_data.b_y;
      pt[1][2] = req_data.b_z;
   end

   // ---------------- flow control: whole pipe holds while the output word waits
   logic         rsp_valid_ff;
   rsp_word_type rsp_data_ff;
   logic         adv;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- stage 1: matrix products
   logic                     v1_ff;
   logic signed [PROD_W-1:0] prod1_ff [2][4][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < 2; e++)
            for (int i = 0; i < 4; i++)
               for (int j = 0; j < 3; j++)
                  prod1_ff[e][i][j] <= mat[i][j] * pt[e][j];
      end
   end

   // ---------------- stage 2: row sums plus translation term
   logic                 v2_ff;
   logic signed [CW-1:0] clip2_ff [2][4];
   logic signed [CW-1:0] clip2_in [2][4];

   always_comb begin
      for (int e = 0; e < 2; e++)
         for (int i = 0; i < 4; i++)
            clip2_in[e][i] = CW'(prod1_ff[e][i][0]) + CW'(prod1_ff[e][i][1])
                           + CW'(prod1_ff[e][i][2])
                           + (CW'(mat[i][3]) <<< WORLD_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) clip2_ff <= clip2_in;
   end

   // ---------------- stage 3: near test, clip numerator and denominator
   logic          v3_ff;
   clip_side_type side3_ff;
   clip_side_type side3_in;
   logic [MW-1:0] dmag3_ff [3];
   logic [MW-1:0] dmag3_in [3];
   logic [MW-1:0] nmag3_ff;
   logic [MW-1:0] nmag3_in;

   always_comb begin
      logic signed [DW-1:0] diff;
      logic signed [DW-1:0] num;
      logic signed [DW-1:0] den;
      num = DW'(NEAR_EPS) - DW'(clip2_ff[0][3]);
      den = DW'(clip2_ff[1][3]) - DW'(clip2_ff[0][3]);
      side3_in.fa  = clip2_ff[0][3] > NEAR_EPS;
      side3_in.fb  = clip2_ff[1][3] > NEAR_EPS;
      side3_in.den = mag_c(den);
      side3_in.ca  = clip2_ff[0];
      side3_in.cb  = clip2_ff[1];
      nmag3_in     = mag_c(num);
      for (int i = 0; i < 3; i++) begin
         diff = DW'(clip2_ff[1][i]) - DW'(clip2_ff[0][i]);
         dmag3_in[i]     = mag_c(diff);
         side3_in.neg[i] = diff[DW-1] ^ num[DW-1] ^ den[DW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side3_ff <= side3_in;
         dmag3_ff <= dmag3_in;
         nmag3_ff <= nmag3_in;
      end
   end

   // ---------------- stage 4: split products diff * num
   logic          v4_ff;
   clip_side_type side4_ff;
   logic [PPW-1:0] pp4_ff [3][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side4_ff <= side3_ff;
         for (int i = 0; i < 3; i++) begin
            pp4_ff[i][0] <= PPW'(dmag3_ff[i][HC-1:0]) * PPW'(nmag3_ff[HC-1:0]);
            pp4_ff[i][1] <= PPW'(dmag3_ff[i][HC-1:0]) * PPW'(nmag3_ff[MW-1:HC]);
            pp4_ff[i][2] <= PPW'(dmag3_ff[i][MW-1:HC]) * PPW'(nmag3_ff[HC-1:0]);
            pp4_ff[i][3] <= PPW'(dmag3_ff[i][MW-1:HC]) * PPW'(nmag3_ff[MW-1:HC]);
         end
      end
   end

   // ---------------- clip divider: stage 0 holds the rounded dividend
   logic          cv_ff    [QC+1];
   clip_side_type cside_ff [QC+1];
   logic [MW-1:0] crem_ff  [QC+1][3];
   logic [QC-1:0] clow_ff  [QC+1][3];
   logic [QC-1:0] cquo_ff  [QC+1][3];

   logic [DVC-1:0] cdiv_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++)
         cdiv_in[i] = DVC'(pp4_ff[i][0])
                    + ((DVC'(pp4_ff[i][1]) + DVC'(pp4_ff[i][2])) << HC)
                    + (DVC'(pp4_ff[i][3]) << (2 * HC))
                    + DVC'(side4_ff.den >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QC; k++) cv_ff[k] <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= v4_ff;
         for (int k = 0; k < QC; k++) cv_ff[k+1] <= cv_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      logic [MW:0] rs;
      logic        ge;
      if (adv) begin
         cside_ff[0] <= side4_ff;
         for (int i = 0; i < 3; i++) begin
            crem_ff[0][i] <= cdiv_in[i][DVC-1:QC];
            clow_ff[0][i] <= cdiv_in[i][QC-1:0];
            cquo_ff[0][i] <= '0;
         end
         for (int k = 0; k < QC; k++) begin
            cside_ff[k+1] <= cside_ff[k];
            for (int i = 0; i < 3; i++) begin
               rs = {crem_ff[k][i], clow_ff[k][i][QC-1]};
               ge = rs >= {1'b0, cside_ff[k].den};
               if (ge) rs = rs - {1'b0, cside_ff[k].den};
               crem_ff[k+1][i] <= rs[MW-1:0];
               clow_ff[k+1][i] <= {clow_ff[k][i][QC-2:0], 1'b0};
               cquo_ff[k+1][i] <= {cquo_ff[k][i][QC-2:0], ge};
            end
         end
      end
   end

   // ---------------- T1: clipped endpoint and endpoint select
   logic                 vt1_ff;
   logic                 vist1_ff;
   logic signed [SW-1:0] pa1_ff [4];
   logic signed [SW-1:0] pb1_ff [4];
   logic signed [SW-1:0] pa1_in [4];
   logic signed [SW-1:0] pb1_in [4];

   always_comb begin
      logic signed [SW-1:0] qs;
      logic signed [SW-1:0] cl;
      for (int i = 0; i < 3; i++) begin
         qs = SW'({1'b0, cquo_ff[QC][i]});
         if (cside_ff[QC].neg[i]) qs = -qs;
         cl = SW'(cside_ff[QC].ca[i]) + qs;
         pa1_in[i] = cside_ff[QC].fa ? SW'(cside_ff[QC].ca[i]) : cl;
         pb1_in[i] = cside_ff[QC].fb ? SW'(cside_ff[QC].cb[i]) : cl;
      end
      pa1_in[3] = cside_ff[QC].fa ? SW'(cside_ff[QC].ca[3]) : SW'(NEAR_EPS);
      pb1_in[3] = cside_ff[QC].fb ? SW'(cside_ff[QC].cb[3]) : SW'(NEAR_EPS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vt1_ff <= 1'b0;
      end else if (adv) begin
         vt1_ff <= cv_ff[QC];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vist1_ff <= cside_ff[QC].fa | cside_ff[QC].fb;
         pa1_ff   <= pa1_in;
         pb1_ff   <= pb1_in;
      end
   end

   // ---------------- T2: numerators and 2w
   logic                  vt2_ff;
   logic                  vist2_ff;
   logic signed [SAW-1:0] sa2_ff [4];
   logic [UCW-1:0]        uca2_ff;
   logic [UCW-1:0]        ucb2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vt2_ff <= 1'b0;
      end else if (adv) begin
         vt2_ff <= vt1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vist2_ff  <= vist1_ff;
         sa2_ff[0] <= SAW'(pa1_ff[0]) + SAW'(pa1_ff[3]);
         sa2_ff[1] <= SAW'(pa1_ff[3]) - SAW'(pa1_ff[1]);
         sa2_ff[2] <= SAW'(pb1_ff[0]) + SAW'(pb1_ff[3]);
         sa2_ff[3] <= SAW'(pb1_ff[3]) - SAW'(pb1_ff[1]);
         uca2_ff   <= {pa1_ff[3][UCW-2:0], 1'b0};
         ucb2_ff   <= {pb1_ff[3][UCW-2:0], 1'b0};
      end
   end

   // ---------------- T3: magnitudes
   logic           vt3_ff;
   scr_side_type   sside3_ff;
   logic [SMW-1:0] smag3_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         vt3_ff <= 1'b0;
      end else if (adv) begin
         vt3_ff <= vt2_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [SAW-1:0] n;
      if (adv) begin
         sside3_ff.vis <= vist2_ff;
         sside3_ff.ovf <= '0;
         sside3_ff.uca <= uca2_ff;
         sside3_ff.ucb <= ucb2_ff;
         for (int i = 0; i < 4; i++) begin
            n = -sa2_ff[i];
            sside3_ff.neg[i] <= sa2_ff[i][SAW-1];
            smag3_ff[i] <= sa2_ff[i][SAW-1] ? n[SMW-1:0] : sa2_ff[i][SMW-1:0];
         end
      end
   end

   // ---------------- T4: split products by viewport size
   logic                       vt4_ff;
   scr_side_type               sside4_ff;
   logic [SH+WDW-1:0]          splo4_ff [4];
   logic [SMW-SH+WDW-1:0]      sphi4_ff [4];
   logic [WDW-1:0]             scale [4];

   always_comb begin
      scale[0] = {size_ff[15:0], SCREEN_FRAC_BITS'(0)};
      scale[1] = {size_ff[31:16], SCREEN_FRAC_BITS'(0)};
      scale[2] = scale[0];
      scale[3] = scale[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vt4_ff <= 1'b0;
      end else if (adv) begin
         vt4_ff <= vt3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sside4_ff <= sside3_ff;
         for (int i = 0; i < 4; i++) begin
            splo4_ff[i] <= (SH+WDW)'(smag3_ff[i][SH-1:0]) * (SH+WDW)'(scale[i]);
            sphi4_ff[i] <= (SMW-SH+WDW)'(smag3_ff[i][SMW-1:SH])
                         * (SMW-SH+WDW)'(scale[i]);
         end
      end
   end

   // ---------------- screen divider: stage 0 holds the rounded dividend
   logic           sv_ff    [QS+1];
   scr_side_type   sside_ff [QS+1];
   logic [UCW-1:0] srem_ff  [QS+1][4];
   logic [QS-1:0]  slow_ff  [QS+1][4];
   logic [QS-1:0]  squo_ff  [QS+1][4];

   logic [SDV-1:0] sdiv_in [4];
   scr_side_type   sside0_in;

   always_comb begin
      logic [UCW-1:0] uc;
      sside0_in = sside4_ff;
      for (int i = 0; i < 4; i++) begin
         uc = (i < 2) ? sside4_ff.uca : sside4_ff.ucb;
         sdiv_in[i] = SDV'(splo4_ff[i]) + (SDV'(sphi4_ff[i]) << SH) + SDV'(uc >> 1);
         // quotient of 2^QS or more saturates the output anyway
         sside0_in.ovf[i] = UCW'(sdiv_in[i][SDV-1:QS]) >= uc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QS; k++) sv_ff[k] <= 1'b0;
      end else if (adv) begin
         sv_ff[0] <= vt4_ff;
         for (int k = 0; k < QS; k++) sv_ff[k+1] <= sv_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      logic [UCW:0]   rs;
      logic [UCW-1:0] uc;
      logic           ge;
      if (adv) begin
         sside_ff[0] <= sside0_in;
         for (int i = 0; i < 4; i++) begin
            srem_ff[0][i] <= UCW'(sdiv_in[i][SDV-1:QS]);
            slow_ff[0][i] <= sdiv_in[i][QS-1:0];
            squo_ff[0][i] <= '0;
         end
         for (int k = 0; k < QS; k++) begin
            sside_ff[k+1] <= sside_ff[k];
            for (int i = 0; i < 4; i++) begin
               uc = (i < 2) ? sside_ff[k].uca : sside_ff[k].ucb;
               rs = {srem_ff[k][i], slow_ff[k][i][QS-1]};
               ge = rs >= {1'b0, uc};
               if (ge) rs = rs - {1'b0, uc};
               srem_ff[k+1][i] <= rs[UCW-1:0];
               slow_ff[k+1][i] <= {slow_ff[k][i][QS-2:0], 1'b0};
               squo_ff[k+1][i] <= {squo_ff[k][i][QS-2:0], ge};
            end
         end
      end
   end

   // ---------------- output word: sign, origin offset, saturation
   logic [15:0]            org [4];
   logic signed [OUT_W-1:0] scr [4];
   logic                   vis_out;

   always_comb begin
      logic [QS:0]          qm;
      logic signed [FW-1:0] qs;
      logic signed [FW-1:0] v;
      org[0] = origin_ff[15:0];
      org[1] = origin_ff[31:16];
      org[2] = origin_ff[15:0];
      org[3] = origin_ff[31:16];
      vis_out = sside_ff[QS].vis && (size_ff[15:0] != 16'd0)
                && (size_ff[31:16] != 16'd0);
      for (int i = 0; i < 4; i++) begin
         qm = sside_ff[QS].ovf[i] ? (QS+1)'(1) << QS : {1'b0, squo_ff[QS][i]};
         qs = FW'(qm);
         if (sside_ff[QS].neg[i]) qs = -qs;
         v  = FW'({org[i], SCREEN_FRAC_BITS'(0)}) + qs;
         scr[i] = vis_out ? sat_out(v) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sv_ff[QS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.visible    <= vis_out;
         rsp_data_ff.screen_a_x <= scr[0];
         rsp_data_ff.screen_a_y <= scr[1];
         rsp_data_ff.screen_b_x <= scr[2];
         rsp_data_ff.screen_b_y <= scr[3];
      end
   end

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Testbench for segment_near_clip_project_unit: streams random and directed segments
// and checks every response word against a predictor of the clip/projection math.
// Depends on sncp_pkg and the unit RTL.
`timescale 1ns / 100ps

import sncp_pkg::*;

class seg_scoreboard;
   logic [63:0] rows[4];
   logic [31:0] origin;
   logic [31:0] vsize;
   rsp_word_type expected_q[$];
   int errors;

   function new();
      reset_regs();
      errors = 0;
   endfunction

   function void reset_regs();
      rows[0] = 64'h0000_0000_0000_1000;
      rows[1] = 64'h0000_0000_1000_0000;
      rows[2] = 64'h0000_1000_0000_0000;
      rows[3] = 64'h1000_0000_0000_0000;
      origin = '0;
      vsize = '0;
   endfunction

   function void set_reg(logic [CSR_AW-1:0] idx, logic [63:0] v);
      case (idx)
         CSR_ROW0: rows[0] = v;
         CSR_ROW1: rows[1] = v;
         CSR_ROW2: rows[2] = v;
         CSR_ROW3: rows[3] = v;
         CSR_ORIGIN: origin = v[31:0];
         CSR_SIZE: vsize = v[31:0];
         default: ;
      endcase
   endfunction

   // round(a*b/c), ties away from zero, magnitude held at 2^60
   function longint scale_div(longint a, longint b, longint c);
      logic [127:0] ua, ub, uc, q;
      bit neg;
      if (c == 0) return 0;
      neg = ((a < 0) != (b < 0)) != (c < 0);
      ua = 128'(a < 0 ? -a : a);
      ub = 128'(b < 0 ? -b : b);
      uc = 128'(c < 0 ? -c : c);
      q = (ua * ub + (uc >> 1)) / uc;
      if (q > (128'd1 << 60)) q = 128'd1 << 60;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function logic signed [OUT_W-1:0] clamp24(longint v);
      if (v > 64'sd8388607) v = 8388607;
      if (v < -64'sd8388608) v = -8388608;
      return v[OUT_W-1:0];
   endfunction

   function void to_clip(longint p[3], output longint c[4]);
      logic signed [15:0] e;
      longint s;
      for (int i = 0; i < 4; i++) begin
         e = rows[i][63:48];
         s = longint'(e) <<< WORLD_FRAC_BITS;
         for (int j = 0; j < 3; j++) begin
            e = rows[i][16*j +: 16];
            s += longint'(e) * p[j];
         end
         c[i] = s;
      end
   endfunction

   function void to_pixel(longint c[4], output logic signed [OUT_W-1:0] ox,
                          output logic signed [OUT_W-1:0] oy);
      longint wd, ht, x0, y0;
      wd = longint'(vsize[15:0]) << SCREEN_FRAC_BITS;
      ht = longint'(vsize[31:16]) << SCREEN_FRAC_BITS;
      x0 = longint'(origin[15:0]) << SCREEN_FRAC_BITS;
      y0 = longint'(origin[31:16]) << SCREEN_FRAC_BITS;
      ox = clamp24(x0 + scale_div(c[0] + c[3], wd, 2 * c[3]));
      oy = clamp24(y0 + scale_div(c[3] - c[1], ht, 2 * c[3]));
   endfunction

   function void note_segment(req_word_type w);
      longint pa[3], pb[3], ca[4], cb[4], cl[4], num, den, eps;
      bit fa, fb;
      rsp_word_type r;
      r = '0;
      eps = NEAR_EPS_L;
      pa[0] = longint'(w.a_x); pa[1] = longint'(w.a_y); pa[2] = longint'(w.a_z);
      pb[0] = longint'(w.b_x); pb[1] = longint'(w.b_y); pb[2] = longint'(w.b_z);
      to_clip(pa, ca);
      to_clip(pb, cb);
      fa = ca[3] > eps;
      fb = cb[3] > eps;
      if (vsize[15:0] != 0 && vsize[31:16] != 0 && (fa || fb)) begin
         if (!fa || !fb) begin
            // move the endpoint behind the near plane onto w = eps
            num = eps - ca[3];
            den = cb[3] - ca[3];
            for (int i = 0; i < 3; i++)
               cl[i] = ca[i] + scale_div(cb[i] - ca[i], num, den);
            cl[3] = eps;
            if (!fa) ca = cl;
            else cb = cl;
         end
         r.visible = 1'b1;
         to_pixel(ca, r.screen_a_x, r.screen_a_y);
         to_pixel(cb, r.screen_b_x, r.screen_b_y);
      end
      expected_q.push_back(r);
   endfunction

   function void check_word(rsp_word_type got);
      rsp_word_type exp_w;
      if (expected_q.size() == 0) begin
         errors++;
         if (errors <= 10) $display("tb: response with nothing pending: %p", got);
         return;
      end
      exp_w = expected_q.pop_front();
      if (exp_w.visible !== got.visible || exp_w.screen_a_x !== got.screen_a_x ||
          exp_w.screen_a_y !== got.screen_a_y || exp_w.screen_b_x !== got.screen_b_x ||
          exp_w.screen_b_y !== got.screen_b_y) begin
         errors++;
         if (errors <= 10)
            $display({"tb: mismatch exp vis=%0d a=(%0d,%0d) b=(%0d,%0d)",
                      " got vis=%0d a=(%0d,%0d) b=(%0d,%0d)"},
                     exp_w.visible, exp_w.screen_a_x, exp_w.screen_a_y, exp_w.screen_b_x,
                     exp_w.screen_b_y, got.visible, got.screen_a_x, got.screen_a_y,
                     got.screen_b_x, got.screen_b_y);
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module tb;
   localparam logic [CSR_AW-1:0] CSR_UNUSED = 3'd6;
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   seg_scoreboard sb = new();
   bit hold_request = 1'b0;
   bit burst_mode = 1'b0;

   segment_near_clip_project_unit dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_segment(req_data);
         if (rsp_valid && !rsp_stall) sb.check_word(rsp_data);
      end
   end

   // receiver back-pressure
   initial begin
      int pct;
      int n;
      pct = 0;
      n = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            if (n == 0) begin
               n = $urandom_range(50, 300);
               case ($urandom_range(0, 3))
                  0: pct = 0;
                  1: pct = 15;
                  2: pct = 40;
                  default: pct = 75;
               endcase
            end
            n--;
            if ($urandom_range(0, 199) == 0) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(10, 60)) @(posedge clock);
            end
            rsp_stall <= ($urandom_range(0, 99) < pct);
         end
      end
   end

   initial begin
      #15ms;
      $display("tb: errors");
      $finish;
   end

   task automatic write_reg(logic [CSR_AW-1:0] idx, logic [63:0] v);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_segment(req_word_type w);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] coord(int kind);
      case (kind)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
         default: return 32'($signed($urandom_range(0, 32'h0014_0000)) - 32'sh000a_0000);
      endcase
   endfunction

   function automatic req_word_type random_segment();
      req_word_type w;
      int k;
      k = $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 2);
      w.a_x = coord(k); w.a_y = coord(k); w.b_x = coord(k); w.b_y = coord(k);
      // depth kept near the camera so one end often falls behind the near plane
      w.a_z = coord(k == 0 ? 0 : 2);
      w.b_z = coord(k == 0 ? 0 : 2);
      return w;
   endfunction

   task automatic random_run(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         send_segment(random_segment());
      end
      burst_mode = 1'b0;
   endtask

   function automatic logic [63:0] mild_row();
      logic [63:0] v;
      for (int j = 0; j < 4; j++)
         v[16*j +: 16] = 16'($signed($urandom_range(0, 16'h4000)) - 16'sh2000);
      return v;
   endfunction

   function automatic req_word_type seg(logic [31:0] ax, ay, az, bx, by, bz);
      req_word_type w;
      w.a_x = ax; w.a_y = ay; w.a_z = az; w.b_x = bx; w.b_y = by; w.b_z = bz;
      return w;
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: zero viewport rejects everything
      send_segment(seg(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0));
      send_segment(seg(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'hFFFF_FFFF));
      settle();

      // perspective: w = -z, 640x480 viewport
      write_reg(CSR_SIZE, {32'hDEAD_BEEF, 16'd480, 16'd640});
      write_reg(CSR_ORIGIN, {32'h1234_5678, 16'd8, 16'd16});
      write_reg(CSR_ROW3, 64'h0000_F000_0000_0000);
      write_reg(CSR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      send_segment(seg(32'h0001_0000, 32'hFFFF_0000, 32'hFFFE_0000,
                       32'hFFFF_8000, 32'h0000_8000, 32'hFFFB_0000)); // both in front
      send_segment(seg(32'h0001_0000, 32'h0002_0000, 32'h0002_0000,
                       32'h0001_0000, 32'hFFFF_0000, 32'hFFFE_0000)); // A behind
      send_segment(seg(32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000,
                       32'hFFF0_0000, 32'h0000_0000, 32'h0001_0000)); // B behind
      send_segment(seg(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                       32'h0000_0000, 32'h0000_0000, 32'h0000_0000)); // both behind
      send_segment(seg(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0100)); // tiny w, huge x
      send_segment(seg(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFE,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
      send_segment(seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      random_run(150);
      // let the pipeline fill against a held-off receiver
      hold_request = 1'b1;
      random_run(300);
      settle();

      // extreme viewport, identity rows, then full-range rows
      write_reg(CSR_ROW3, 64'h1000_0000_0000_0000);
      write_reg(CSR_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_ORIGIN, 64'hFFFF_FFFF_FFFF_FFFF);
      send_segment(seg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_segment(seg(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
      random_run(100);
      settle();
      write_reg(CSR_ROW0, {$urandom, $urandom});
      write_reg(CSR_ROW1, {$urandom, $urandom});
      write_reg(CSR_ROW2, 64'h8000_7FFF_8000_7FFF);
      write_reg(CSR_ROW3, 64'h7FFF_8000_7FFF_8000);
      random_run(150);
      settle();

      // one viewport dimension zero rejects
      write_reg(CSR_SIZE, {32'h0, 16'd0, 16'd100});
      random_run(30);
      settle();
      write_reg(CSR_SIZE, {32'h0, 16'd100, 16'd0});
      random_run(30);
      settle();

      // several mild random perspective settings
      for (int p = 0; p < 5; p++) begin
         write_reg(CSR_ROW0, mild_row());
         write_reg(CSR_ROW1, mild_row());
         write_reg(CSR_ROW2, mild_row());
         write_reg(CSR_ROW3, {16'($urandom_range(0, 16'h1000)),
                              16'hF000 + 16'($urandom_range(0, 16'h0800)),
                              16'($urandom_range(0, 16'h0400)),
                              16'($urandom_range(0, 16'h0400))});
         write_reg(CSR_ORIGIN, {$urandom, $urandom});
         write_reg(CSR_SIZE, {32'h0, 16'($urandom_range(1, 16'hFFFF)),
                              16'($urandom_range(1, 16'hFFFF))});
         random_run(150);
         settle();
      end

      if (sb.pending() != 0) sb.errors++;
      if (sb.errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end
endmodule
